/* hw/rtl/lft_pkg.sv */
// Package for the learned feed-forward table: sizes, command and register codes,
// state types and the structs passed between the table, the mul/div unit and control.
// No dependencies.
`default_nettype none

package lft_pkg;

    // Table geometry and data widths
    localparam int ENTRIES = 4;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int DATA_W  = 16;
    localparam int PROD_W  = 2 * DATA_W;

    // Serial mul/div step counts
    localparam int MUL_STEPS = DATA_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration reset values
    localparam logic [3:0]        LEARN_SHIFT_RST    = 4'd3;
    localparam logic [9:0]        MAX_CORRECTION_RST = 10'd20;
    localparam logic [DATA_W-1:0] MAX_STEPS_RST      = 16'd3000;

    // Configuration register indexes
    localparam logic [1:0] CFG_LEARN_SHIFT    = 2'd0;
    localparam logic [1:0] CFG_MAX_CORRECTION = 2'd1;
    localparam logic [1:0] CFG_MAX_STEPS      = 2'd2;

    typedef enum logic [1:0] {
        CMD_LEARN  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_CLEAR,
        UPD_FRONT
    } upd_kind_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SETUP,
        ST_MULDIV,
        ST_POST,
        ST_CLAMP,
        ST_OUT
    } ctrl_state_t;

    // Outcome of one pass over the table
    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [DATA_W-1:0] hit_s;
        logic              lo_ok;
        logic [DATA_W-1:0] lo_t;
        logic [DATA_W-1:0] lo_s;
        logic              hi_ok;
        logic [DATA_W-1:0] hi_t;
        logic [DATA_W-1:0] hi_s;
    } scan_res_t;

    // Table write request
    typedef struct packed {
        upd_kind_t         kind;
        logic [IDX_W-1:0]  from_idx;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } table_upd_t;

    // Operands of (mul_a * mul_b) / div_d
    typedef struct packed {
        logic [DATA_W-1:0] mul_a;
        logic [DATA_W-1:0] mul_b;
        logic [DATA_W-1:0] div_d;
    } md_op_t;

endpackage

`default_nettype wire

/* hw/rtl/lft_table.sv */
// Most-recently-used key/steps table with a serial search, one entry per cycle.
// Depends on lft_pkg.
`default_nettype none

module lft_table
    import lft_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              scan_start,
    input  wire logic [DATA_W-1:0] key,
    input  wire table_upd_t        upd,
    output logic                   scan_done,
    output scan_res_t              res
);

    logic [DATA_W-1:0] entry_target_reg [ENTRIES];
    logic [DATA_W-1:0] entry_steps_reg  [ENTRIES];
    logic [DATA_W-1:0] entry_target_next [ENTRIES];
    logic [DATA_W-1:0] entry_steps_next  [ENTRIES];

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    scan_res_t        res_reg, res_next;

    logic [DATA_W-1:0] cur_t;
    logic [DATA_W-1:0] cur_s;

    assign cur_t = entry_target_reg[idx_reg];
    assign cur_s = entry_steps_reg[idx_reg];

    // Walk the entries, keeping the exact hit and the nearest keys on either side
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (scan_start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            res_next  = '0;
        end else if (busy_reg) begin
            if (cur_t != '0) begin
                if (cur_t == key) begin
                    if (!res_reg.hit) begin
                        res_next.hit     = 1'b1;
                        res_next.hit_idx = idx_reg;
                        res_next.hit_s   = cur_s;
                    end
                end else if (cur_t < key) begin
                    if (!res_reg.lo_ok || cur_t > res_reg.lo_t) begin
                        res_next.lo_ok = 1'b1;
                        res_next.lo_t  = cur_t;
                        res_next.lo_s  = cur_s;
                    end
                end else begin
                    if (!res_reg.hi_ok || cur_t < res_reg.hi_t) begin
                        res_next.hi_ok = 1'b1;
                        res_next.hi_t  = cur_t;
                        res_next.hi_s  = cur_s;
                    end
                end
            end
            if (idx_reg == IDX_W'(ENTRIES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Clear, or shift the older entries back and put the new pair in front
    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            entry_target_next[j] = entry_target_reg[j];
            entry_steps_next[j]  = entry_steps_reg[j];
        end
        unique case (upd.kind)
            UPD_CLEAR: begin
                for (int j = 0; j < ENTRIES; j++) begin
                    entry_target_next[j] = '0;
                    entry_steps_next[j]  = '0;
                end
            end
            UPD_FRONT: begin
                entry_target_next[0] = upd.key;
                entry_steps_next[0]  = upd.value;
                for (int j = 1; j < ENTRIES; j++) begin
                    if (IDX_W'(j) <= upd.from_idx) begin
                        entry_target_next[j] = entry_target_reg[j-1];
                        entry_steps_next[j]  = entry_steps_reg[j-1];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                entry_target_reg[j] <= '0;
                entry_steps_reg[j]  <= '0;
            end
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
            for (int j = 0; j < ENTRIES; j++) begin
                entry_target_reg[j] <= entry_target_next[j];
                entry_steps_reg[j]  <= entry_steps_next[j];
            end
        end
    end

    // Hold the search result
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign scan_done = done_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/lft_muldiv.sv */
// Bit-serial unit computing floor(a * b / d): shift-add multiply, then restoring divide.
// Depends on lft_pkg.
`default_nettype none

module lft_muldiv
    import lft_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire md_op_t            op,
    output logic                   done,
    output logic [PROD_W-1:0]      quot
);

    md_phase_t         phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] d_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [DATA_W-1:0] rem_reg;

    logic [DATA_W:0]   sum_w;
    logic [DATA_W:0]   trial_w;
    logic [DATA_W:0]   diff_w;
    logic              ge_w;

    // One multiplier bit per cycle: add into the upper half, shift right
    assign sum_w = {1'b0, acc_reg[PROD_W-1:DATA_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);

    // One quotient bit per cycle: shift in a dividend bit, subtract if it fits
    assign trial_w = {rem_reg, acc_reg[PROD_W-1]};
    assign diff_w  = trial_w - {1'b0, d_reg};
    assign ge_w    = trial_w >= {1'b0, d_reg};

    // Phase sequencing
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            MD_IDLE: begin
                if (start) begin
                    phase_next = MD_MUL;
                    cnt_next   = '0;
                end
            end
            MD_MUL: begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    phase_next = MD_DIV;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MD_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    phase_next = MD_IDLE;
                    done_next  = 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: phase_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Operand and shift registers
    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            MD_IDLE: begin
                if (start) begin
                    a_reg   <= op.mul_a;
                    d_reg   <= op.div_d;
                    acc_reg <= {{DATA_W{1'b0}}, op.mul_b};
                    rem_reg <= '0;
                end
            end
            MD_MUL: begin
                acc_reg <= {sum_w, acc_reg[DATA_W-1:1]};
            end
            MD_DIV: begin
                rem_reg <= ge_w ? diff_w[DATA_W-1:0] : trial_w[DATA_W-1:0];
                acc_reg <= {acc_reg[PROD_W-2:0], ge_w};
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign quot = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/learned_feedforward_table_top.sv */
// Learned feed-forward table: a learn hit, or a lookup that interpolates or extrapolates,
// goes from the table scan through a serial multiply and a serial divide to the result;
// every other transaction goes from the scan straight to the result.
// One transaction at a time: the next is accepted the cycle after the result is
// loaded into the output register. A synchronous low aresetn empties the table,
// restores the configuration defaults, drops any pending result and holds both readies low.
`default_nettype none

module learned_feedforward_table_top
    import lft_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration write
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    // input transactions
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic [DATA_W-1:0] s_target,
    input  wire logic [DATA_W-1:0] s_actual,
    input  wire logic [DATA_W-1:0] s_steps,
    // results
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_steps_out,
    output logic                   m_matched,
    output logic                   m_saturated
);

    ctrl_state_t state_reg, state_next;

    logic [3:0]        learn_shift_reg;
    logic [9:0]        max_correction_reg;
    logic [DATA_W-1:0] max_steps_reg;

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] tgt_reg;
    logic [DATA_W-1:0] act_reg;
    logic [DATA_W-1:0] stp_reg;

    logic [DATA_W-1:0] base_reg;
    logic              neg_reg;
    logic signed [PROD_W:0] val_reg;

    logic [DATA_W-1:0] res_steps_reg;
    logic              res_matched_reg;
    logic              res_sat_reg;
    upd_kind_t         upd_kind_reg;
    logic [IDX_W-1:0]  upd_from_reg;
    logic [DATA_W-1:0] upd_s_reg;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_steps_out_reg;
    logic              m_matched_reg;
    logic              m_saturated_reg;

    // control strobes
    logic       accept;
    logic       scan_start;
    logic       md_start;
    logic       out_load;
    table_upd_t upd;

    scan_res_t         tres;
    logic              scan_done;
    logic              md_done;
    logic [PROD_W-1:0] md_quot;

    // setup decision
    logic              need_calc;
    md_op_t            dec_op;
    logic [DATA_W-1:0] dec_base;
    logic              dec_neg;
    logic [DATA_W-1:0] dec_steps;
    logic              dec_matched;
    upd_kind_t         dec_upd_kind;
    logic [IDX_W-1:0]  dec_from;

    // post-processing
    logic signed [PROD_W:0]     sval_w;
    logic signed [PROD_W:0]     lim_w;
    logic signed [PROD_W:0]     delta_w;
    logic signed [PROD_W+1:0]   ns_w;
    logic signed [PROD_W+1:0]   r_w;
    logic signed [PROD_W+1:0]   max_steps_w;
    logic [DATA_W-1:0]          learn_steps_w;
    logic [DATA_W-1:0]          lookup_steps_w;
    logic                       lookup_sat_w;

    lft_table u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scan_start (scan_start),
        .key        (tgt_reg),
        .upd        (upd),
        .scan_done  (scan_done),
        .res        (tres)
    );

    lft_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (md_start),
        .op      (dec_op),
        .done    (md_done),
        .quot    (md_quot)
    );

    assign accept = s_valid && s_ready;

    // Configuration registers; writes are taken only between transactions
    assign cfg_ready = aresetn && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_shift_reg    <= LEARN_SHIFT_RST;
            max_correction_reg <= MAX_CORRECTION_RST;
            max_steps_reg      <= MAX_STEPS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LEARN_SHIFT:    learn_shift_reg    <= cfg_data[3:0];
                CFG_MAX_CORRECTION: max_correction_reg <= cfg_data[9:0];
                CFG_MAX_STEPS:      max_steps_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SCAN;
            ST_SCAN:   if (scan_done) state_next = ST_SETUP;
            ST_SETUP:  state_next = need_calc ? ST_MULDIV : ST_OUT;
            ST_MULDIV: if (md_done) state_next = ST_POST;
            ST_POST:   state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_ready      = aresetn && (state_reg == ST_IDLE);
        scan_start   = (state_reg == ST_IDLE) && s_valid;
        md_start     = (state_reg == ST_SETUP) && need_calc;
        out_load     = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
        upd.kind     = out_load ? upd_kind_reg : UPD_NONE;
        upd.from_idx = upd_from_reg;
        upd.key      = tgt_reg;
        upd.value    = upd_s_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decide the operation from the command and the search result
    always_comb begin
        need_calc    = 1'b0;
        dec_op       = '0;
        dec_base     = '0;
        dec_neg      = 1'b0;
        dec_steps    = '0;
        dec_matched  = 1'b0;
        dec_upd_kind = UPD_NONE;
        dec_from     = tres.hit_idx;
        unique case (cmd_reg)
            CMD_LEARN: begin
                if (tgt_reg != '0) begin
                    dec_upd_kind = UPD_FRONT;
                    if (tres.hit) begin
                        // steps * (target - actual) / target
                        need_calc    = 1'b1;
                        dec_op.mul_a = stp_reg;
                        dec_op.div_d = tgt_reg;
                        if (tgt_reg >= act_reg) begin
                            dec_op.mul_b = tgt_reg - act_reg;
                        end else begin
                            dec_op.mul_b = act_reg - tgt_reg;
                            dec_neg      = 1'b1;
                        end
                    end else begin
                        // miss: oldest entry drops out
                        dec_steps = stp_reg;
                        dec_from  = IDX_W'(ENTRIES - 1);
                    end
                end
            end
            CMD_LOOKUP: begin
                if (tgt_reg != '0) begin
                    priority if (tres.hit) begin
                        dec_steps   = tres.hit_s;
                        dec_matched = 1'b1;
                    end else if (tres.lo_ok && tres.hi_ok) begin
                        // interpolate between neighbors
                        need_calc    = 1'b1;
                        dec_base     = tres.lo_s;
                        dec_op.mul_a = tgt_reg - tres.lo_t;
                        dec_op.div_d = tres.hi_t - tres.lo_t;
                        if (tres.hi_s >= tres.lo_s) begin
                            dec_op.mul_b = tres.hi_s - tres.lo_s;
                        end else begin
                            dec_op.mul_b = tres.lo_s - tres.hi_s;
                            dec_neg      = 1'b1;
                        end
                    end else if (tres.lo_ok) begin
                        // extrapolate above the largest key
                        need_calc    = 1'b1;
                        dec_op.mul_a = tres.lo_s;
                        dec_op.mul_b = tgt_reg;
                        dec_op.div_d = tres.lo_t;
                    end else if (tres.hi_ok) begin
                        // extrapolate below the smallest key
                        need_calc    = 1'b1;
                        dec_base     = tres.hi_s;
                        dec_neg      = 1'b1;
                        dec_op.mul_a = tres.hi_t - tgt_reg;
                        dec_op.mul_b = tres.hi_s;
                        dec_op.div_d = tres.hi_t;
                    end else begin
                        dec_steps = '0;
                    end
                end
            end
            CMD_CLEAR: dec_upd_kind = UPD_CLEAR;
            CMD_NOP:   ;
            default:   ;
        endcase
    end

    // Signed quotient; learn applies the floor shift
    assign sval_w = neg_reg ? -$signed({1'b0, md_quot}) : $signed({1'b0, md_quot});

    // Learn: clamp the correction, then the new steps value
    assign lim_w = $signed({{(PROD_W - 9){1'b0}}, max_correction_reg});

    always_comb begin
        if (val_reg > lim_w) begin
            delta_w = lim_w;
        end else if (val_reg < -lim_w) begin
            delta_w = -lim_w;
        end else begin
            delta_w = val_reg;
        end
    end

    assign ns_w        = $signed({{(PROD_W + 2 - DATA_W){1'b0}}, stp_reg})
                         + $signed({delta_w[PROD_W], delta_w});
    assign max_steps_w = $signed({{(PROD_W + 2 - DATA_W){1'b0}}, max_steps_reg});

    always_comb begin
        if (ns_w < 0) begin
            learn_steps_w = '0;
        end else if (ns_w > max_steps_w) begin
            learn_steps_w = max_steps_reg;
        end else begin
            learn_steps_w = ns_w[DATA_W-1:0];
        end
    end

    // Lookup: add to base, saturate to the output range
    assign r_w = $signed({{(PROD_W + 2 - DATA_W){1'b0}}, base_reg})
                 + $signed({val_reg[PROD_W], val_reg});

    always_comb begin
        lookup_sat_w = 1'b0;
        if (r_w < 0) begin
            lookup_steps_w = '0;
        end else if (r_w > $signed({2'b00, {DATA_W{1'b1}}})) begin
            lookup_steps_w = '1;
            lookup_sat_w   = 1'b1;
        end else begin
            lookup_steps_w = r_w[DATA_W-1:0];
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_t'(s_command);
            tgt_reg <= s_target;
            act_reg <= s_actual;
            stp_reg <= s_steps;
        end
        unique case (state_reg)
            ST_SETUP: begin
                base_reg        <= dec_base;
                neg_reg         <= dec_neg;
                res_steps_reg   <= dec_steps;
                res_matched_reg <= dec_matched;
                res_sat_reg     <= 1'b0;
                upd_kind_reg    <= dec_upd_kind;
                upd_from_reg    <= dec_from;
                upd_s_reg       <= stp_reg;
            end
            ST_POST: begin
                val_reg <= (cmd_reg == CMD_LEARN) ? (sval_w >>> learn_shift_reg) : sval_w;
            end
            ST_CLAMP: begin
                if (cmd_reg == CMD_LEARN) begin
                    res_steps_reg   <= learn_steps_w;
                    res_matched_reg <= 1'b1;
                    upd_s_reg       <= learn_steps_w;
                end else begin
                    res_steps_reg <= lookup_steps_w;
                    res_sat_reg   <= lookup_sat_w;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_steps_out_reg <= res_steps_reg;
            m_matched_reg   <= res_matched_reg;
            m_saturated_reg <= res_sat_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_steps_out = m_steps_out_reg;
    assign m_matched   = m_matched_reg;
    assign m_saturated = m_saturated_reg;

endmodule

`default_nettype wire

/* hw/rtl/learned_feedforward_table_chk.sv */
// Port-level checker for the learned feed-forward table, bound to the top level.
// Depends on lft_pkg and learned_feedforward_table_top.
`default_nettype none

module learned_feedforward_table_chk
    import lft_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [DATA_W-1:0] m_steps_out,
    input wire logic              m_matched,
    input wire logic              m_saturated
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_steps_out)
                                   && $stable(m_matched) && $stable(m_saturated)))
        else $error("result changed while stalled");

    // Saturation always reports the top of the range
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_steps_out == {DATA_W{1'b1}}))
        else $error("saturated result not at full scale");

    // An exact match never saturates
    a_sat_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_saturated && m_matched))
        else $error("matched and saturated together");

    // One transaction in flight: input closes right after acceptance
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while busy");

endmodule

bind learned_feedforward_table_top learned_feedforward_table_chk u_chk (.*);

`default_nettype wire

/* test/lft_table_checker.sv */
// Result checker for the learned feed-forward table: follows the register, input and
// result channels, keeps its own copy of the table and compares every result in order.
// Depends on lft_pkg for widths, command codes, register indexes and reset values.
module lft_table_checker
    import lft_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [1:0]        s_command,
    input  wire logic [DATA_W-1:0] s_target,
    input  wire logic [DATA_W-1:0] s_actual,
    input  wire logic [DATA_W-1:0] s_steps,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [DATA_W-1:0] m_steps_out,
    input  wire logic              m_matched,
    input  wire logic              m_saturated,
    output int                     fail_count,
    output int                     pending,
    output int                     items_seen,
    output int                     results_checked,
    output int                     learn_hits,
    output int                     sat_lookups
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DATA_W-1:0] steps_out;
        logic              matched;
        logic              saturated;
    } table_resp_t;

    // Shadow table, most recent entry in slot 0; key zero marks an empty slot
    logic [DATA_W-1:0] key_tab   [ENTRIES];
    logic [DATA_W-1:0] steps_tab [ENTRIES];

    // Shadow registers
    logic [3:0]        shift_r;
    logic [9:0]        corr_limit_r;
    logic [DATA_W-1:0] steps_ceiling_r;

    table_resp_t pending_responses[$];

    initial begin
        fail_count      = 0;
        pending         = 0;
        items_seen      = 0;
        results_checked = 0;
        learn_hits      = 0;
        sat_lookups     = 0;
    end

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++) begin
            key_tab[i]   = '0;
            steps_tab[i] = '0;
        end
    endfunction

    // Shift older entries down by one and put the pair in slot 0
    function automatic void move_front(int from, logic [DATA_W-1:0] key,
                                       logic [DATA_W-1:0] val);
        for (int j = from; j > 0; j--) begin
            key_tab[j]   = key_tab[j-1];
            steps_tab[j] = steps_tab[j-1];
        end
        key_tab[0]   = key;
        steps_tab[0] = val;
    endfunction

    // Correct an existing pair or insert a new one
    function automatic table_resp_t learned_steps(logic [DATA_W-1:0] tgt,
                                                  logic [DATA_W-1:0] act,
                                                  logic [DATA_W-1:0] stp);
        table_resp_t res;
        int          hit_idx;
        longint      tgt_l, act_l, stp_l, delta, lim, ns, ceil_l;
        res     = '0;
        hit_idx = -1;
        if (tgt == '0)
            return res;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_idx < 0 && key_tab[i] == tgt)
                hit_idx = i;
        if (hit_idx < 0) begin
            // miss: oldest slot drops out, pair goes in unclamped
            move_front(ENTRIES - 1, tgt, stp);
            res.steps_out = stp;
            return res;
        end
        tgt_l  = tgt;
        act_l  = act;
        stp_l  = stp;
        lim    = corr_limit_r;
        ceil_l = steps_ceiling_r;
        // truncating divide, then floor shift
        delta = (stp_l * (tgt_l - act_l)) / tgt_l;
        delta = delta >>> shift_r;
        if (delta > lim)
            delta = lim;
        if (delta < -lim)
            delta = -lim;
        ns = stp_l + delta;
        if (ns < 0)
            ns = 0;
        if (ns > ceil_l)
            ns = ceil_l;
        move_front(hit_idx, tgt, ns[DATA_W-1:0]);
        res.steps_out = ns[DATA_W-1:0];
        res.matched   = 1'b1;
        return res;
    endfunction

    // Exact match, else interpolate between or extrapolate from nearest keys
    function automatic table_resp_t interpolated_steps(logic [DATA_W-1:0] tgt);
        table_resp_t res;
        logic        lo_ok, hi_ok, found;
        longint      q, t, lo_t, lo_s, hi_t, hi_s, r;
        res   = '0;
        lo_ok = 1'b0;
        hi_ok = 1'b0;
        found = 1'b0;
        lo_t  = 0;
        lo_s  = 0;
        hi_t  = 0;
        hi_s  = 0;
        if (tgt == '0)
            return res;
        q = tgt;
        for (int i = 0; i < ENTRIES; i++) begin
            t = key_tab[i];
            if (!found && t != 0) begin
                if (t == q) begin
                    found         = 1'b1;
                    res.steps_out = steps_tab[i];
                    res.matched   = 1'b1;
                end else if (t < q) begin
                    if (!lo_ok || t > lo_t) begin
                        lo_t  = t;
                        lo_s  = steps_tab[i];
                        lo_ok = 1'b1;
                    end
                end else if (!hi_ok || t < hi_t) begin
                    hi_t  = t;
                    hi_s  = steps_tab[i];
                    hi_ok = 1'b1;
                end
            end
        end
        if (found || (!lo_ok && !hi_ok))
            return res;
        if (!lo_ok)
            r = hi_s + ((q - hi_t) * hi_s) / hi_t;
        else if (!hi_ok)
            r = (lo_s * q) / lo_t;
        else
            r = lo_s + ((q - lo_t) * (hi_s - lo_s)) / (hi_t - lo_t);
        if (r < 0)
            r = 0;
        if (r > 65535) begin
            r             = 65535;
            res.saturated = 1'b1;
        end
        res.steps_out = r[DATA_W-1:0];
        return res;
    endfunction

    function automatic table_resp_t table_response(cmd_t cmd, logic [DATA_W-1:0] tgt,
                                                   logic [DATA_W-1:0] act,
                                                   logic [DATA_W-1:0] stp);
        table_resp_t res;
        res = '0;
        case (cmd)
            CMD_LEARN:  res = learned_steps(tgt, act, stp);
            CMD_LOOKUP: res = interpolated_steps(tgt);
            CMD_CLEAR:  clear_table();
            default:    ;
        endcase
        return res;
    endfunction

    // Track register writes, predict on input transactions, compare on result transactions
    always @(posedge aclk) begin : watch
        table_resp_t want, got;
        if (!aresetn) begin
            clear_table();
            shift_r         = LEARN_SHIFT_RST;
            corr_limit_r    = MAX_CORRECTION_RST;
            steps_ceiling_r = MAX_STEPS_RST;
            pending_responses.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LEARN_SHIFT:    shift_r         = cfg_data[3:0];
                    CFG_MAX_CORRECTION: corr_limit_r    = cfg_data[9:0];
                    CFG_MAX_STEPS:      steps_ceiling_r = cfg_data;
                    default:            ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = table_response(cmd_t'(s_command), s_target, s_actual, s_steps);
                pending_responses.push_back(want);
                items_seen++;
                if (cmd_t'(s_command) == CMD_LEARN && want.matched)
                    learn_hits++;
                if (want.saturated)
                    sat_lookups++;
            end
            if (m_valid && m_ready) begin
                got = {m_steps_out, m_matched, m_saturated};
                if (pending_responses.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result steps_out=%0d matched=%0b saturated=%0b",
                                 $realtime, got.steps_out, got.matched, got.saturated);
                end else begin
                    want = pending_responses.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: result mismatch: expected steps_out=%0d ",
                                      "matched=%0b saturated=%0b, got steps_out=%0d ",
                                      "matched=%0b saturated=%0b"},
                                     $realtime, want.steps_out, want.matched, want.saturated,
                                     got.steps_out, got.matched, got.saturated);
                    end
                end
            end
        end
        pending = pending_responses.size();
    end

endmodule

/* test/tb_learned_feedforward_table_top.sv */
// Testbench top for learned_feedforward_table_top: clock, reset, register writes,
// directed and random command transactions with random gaps and back-pressure, verdict.
// Depends on lft_pkg, the block itself and lft_table_checker.
module tb_learned_feedforward_table_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lft_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int KEY_POOL        = 6;
    localparam int DRAIN_CYCLES    = 2 * (ENTRIES + 54);
    localparam int CYCLE_LIMIT     = 1_000_000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_LEARN_SHIFT;
    logic [DATA_W-1:0] cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    cmd_t              s_command = CMD_NOP;
    logic [DATA_W-1:0] s_target  = '0;
    logic [DATA_W-1:0] s_actual  = '0;
    logic [DATA_W-1:0] s_steps   = '0;
    logic              m_valid;
    logic              m_ready   = 1'b1;
    logic [DATA_W-1:0] m_steps_out;
    logic              m_matched;
    logic              m_saturated;

    int fail_count, pending, items_seen, results_checked, learn_hits, sat_lookups;
    int cycle_count = 0;

    logic [DATA_W-1:0] key_pool [KEY_POOL];
    logic              no_gaps    = 1'b0;
    logic              ready_calm = 1'b0;
    int unsigned       stall_left = 0;
    int unsigned       calm_left  = 0;

    learned_feedforward_table_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_target    (s_target),
        .s_actual    (s_actual),
        .s_steps     (s_steps),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_steps_out (m_steps_out),
        .m_matched   (m_matched),
        .m_saturated (m_saturated)
    );

    lft_table_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_target        (s_target),
        .s_actual        (s_actual),
        .s_steps         (s_steps),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_steps_out     (m_steps_out),
        .m_matched       (m_matched),
        .m_saturated     (m_saturated),
        .fail_count      (fail_count),
        .pending         (pending),
        .items_seen      (items_seen),
        .results_checked (results_checked),
        .learn_hits      (learn_hits),
        .sat_lookups     (sat_lookups)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[learned_feedforward_table_top] ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic int unsigned pick_stall();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] clamp16(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return v[DATA_W-1:0];
    endfunction

    // Result back-pressure: alternate calm stretches with random stalls
    always @(negedge aclk) begin
        if (calm_left == 0) begin
            ready_calm = ($urandom_range(0, 3) == 0);
            calm_left  = $urandom_range(100, 600);
        end else begin
            calm_left--;
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (!ready_calm && $urandom_range(0, 2) == 0)
                stall_left = pick_stall();
        end
    end

    // Hold one command until accepted, then idle for a random gap
    task automatic send_item(input cmd_t cmd, input logic [DATA_W-1:0] tgt,
                             input logic [DATA_W-1:0] act, input logic [DATA_W-1:0] stp);
        int unsigned gap;
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_target  <= tgt;
        s_actual  <= act;
        s_steps   <= stp;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // Hold one register write until accepted; caller drops valid afterwards
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [3:0] sh, input logic [9:0] corr,
                              input logic [DATA_W-1:0] ceil_v);
        write_reg(CFG_LEARN_SHIFT, 16'(sh));
        write_reg(CFG_MAX_CORRECTION, 16'(corr));
        write_reg(CFG_MAX_STEPS, ceil_v);
        cfg_valid <= 1'b0;
    endtask

    // New key set per phase, spread over several magnitudes
    task automatic draw_keys();
        for (int k = 0; k < KEY_POOL; k++) begin
            case ($urandom_range(0, 3))
                0:       key_pool[k] = 16'($urandom_range(1, 15));
                1:       key_pool[k] = 16'($urandom_range(16, 255));
                2:       key_pool[k] = 16'($urandom_range(256, 4095));
                default: key_pool[k] = 16'($urandom_range(4096, 65535));
            endcase
        end
    endtask

    task automatic random_item();
        int unsigned       pick;
        int                span;
        cmd_t              cmd;
        logic [DATA_W-1:0] tgt, act, stp;
        pick = $urandom_range(0, 99);
        if (pick < 48)
            cmd = CMD_LEARN;
        else if (pick < 94)
            cmd = CMD_LOOKUP;
        else if (pick < 97)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_NOP;
        // mostly pool keys so learns hit and lookups find neighbors
        pick = $urandom_range(0, 99);
        if (pick < 70)
            tgt = key_pool[$urandom_range(0, KEY_POOL - 1)];
        else if (pick < 80)
            tgt = clamp16(int'(key_pool[$urandom_range(0, KEY_POOL - 1)])
                          + int'($urandom_range(0, 128)) - 64);
        else if (pick < 94)
            tgt = 16'($urandom);
        else if (pick < 97)
            tgt = '0;
        else
            tgt = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
        // measured value mostly near the target
        pick = $urandom_range(0, 99);
        span = int'(tgt) / 4;
        if (pick < 50)
            act = clamp16(int'(tgt) + int'($urandom_range(0, 2 * span)) - span);
        else if (pick < 80)
            act = 16'($urandom);
        else if (pick < 90)
            act = tgt;
        else
            act = ($urandom_range(0, 1) != 0) ? 16'hFFFF : '0;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            stp = 16'($urandom_range(0, 3000));
        else if (pick < 80)
            stp = 16'($urandom);
        else if (pick < 90)
            stp = '0;
        else
            stp = 16'hFFFF;
        send_item(cmd, tgt, act, stp);
    endtask

    initial begin
        // Reset
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table, zero keys, insert, exact, between, below, above
        send_item(CMD_LOOKUP, 16'd100, 16'd0, 16'd0);
        send_item(CMD_LEARN, 16'd0, 16'd123, 16'd456);
        send_item(CMD_LEARN, 16'd1000, 16'd0, 16'd500);
        send_item(CMD_LEARN, 16'd3000, 16'd0, 16'd2000);
        send_item(CMD_LOOKUP, 16'd0, 16'd0, 16'd0);
        send_item(CMD_LOOKUP, 16'd1000, 16'd0, 16'd0);
        send_item(CMD_LOOKUP, 16'd2000, 16'd0, 16'd0);
        send_item(CMD_LOOKUP, 16'd500, 16'd0, 16'd0);
        send_item(CMD_LOOKUP, 16'hFFFF, 16'd0, 16'd0);
        // Learn hits: positive, negative floor, both clamps, below zero
        send_item(CMD_LEARN, 16'd1000, 16'd900, 16'd500);
        send_item(CMD_LEARN, 16'd1000, 16'd1100, 16'd506);
        send_item(CMD_LEARN, 16'd1000, 16'd0, 16'd60000);
        send_item(CMD_LEARN, 16'd1000, 16'hFFFF, 16'd10);
        // Fill the table and evict the oldest entry
        send_item(CMD_LEARN, 16'd5, 16'd0, 16'd1);
        send_item(CMD_LEARN, 16'd7000, 16'd0, 16'd100);
        send_item(CMD_LEARN, 16'd9, 16'd9, 16'd9);
        send_item(CMD_LOOKUP, 16'd3000, 16'd0, 16'd0);
        // No-op and clear
        send_item(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(CMD_LOOKUP, 16'd1000, 16'd0, 16'd0);
        // Saturation and the widest keys
        send_item(CMD_LEARN, 16'd1, 16'd0, 16'hFFFF);
        send_item(CMD_LOOKUP, 16'hFFFF, 16'd0, 16'd0);
        send_item(CMD_LEARN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_LEARN, 16'hFFFF, 16'd0, 16'hFFFF);
        send_item(CMD_LOOKUP, 16'd32768, 16'd0, 16'd0);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0:          set_config(4'd0, 10'd0, 16'd0);
                1:          set_config(4'd15, 10'd1023, 16'hFFFF);
                2:          set_config(4'd0, 10'd1023, 16'hFFFF);
                3:          set_config(4'd15, 10'd0, 16'hFFFF);
                PHASES - 1: set_config(LEARN_SHIFT_RST, MAX_CORRECTION_RST, MAX_STEPS_RST);
                default:    set_config(4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)),
                                       16'($urandom));
            endcase
            draw_keys();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 64 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end

        // Drain and report
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d transactions under %0d register settings plus reset values.",
                 items_seen, PHASES);
        $display("Checked %0d results: %0d corrected learn hits, %0d saturated lookups.",
                 results_checked, learn_hits, sat_lookups);
        if (fail_count == 0 && pending == 0)
            $display("[learned_feedforward_table_top] OK");
        else
            $display("[learned_feedforward_table_top] ERROR");
        $finish;
    end

endmodule
